@@ rtl/core/hld_pkg.sv @@
// Shared types and constants for the Huffman literal decoder.
// Used by hld_front, hld_back and the top level; no dependencies.
package hld_pkg;
  localparam int TableLog = 11;
  localparam int TableSize = 1 << TableLog;
  localparam int SymbolCount = 256;
  localparam int QueueDepth = 2;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_BYTE = 2'd3;

  localparam logic [1:0] KIND_LIT = 2'd0;
  localparam logic [1:0] KIND_BUILD = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOSYM = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE = 3'd2;
  localparam logic [2:0] ST_DEEP = 3'd3;
  localparam logic [2:0] ST_MANY = 3'd4;
  localparam logic [2:0] ST_ZERO = 3'd5;
  localparam logic [2:0] ST_SHORT = 3'd6;

  // one queued transaction between front and back
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  value;
    logic [17:0] count;
    logic        fin;
  } item_t;
endpackage

@@ rtl/core/hld_front.sv @@
// Front end: accepts transactions into a short queue.
// Depends on hld_pkg.
module hld_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hld_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output hld_pkg::item_t  head
);
  hld_pkg::item_t q_r [hld_pkg::QueueDepth];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'(hld_pkg::QueueDepth));
  assign avail = (cnt_r != 2'd0);
  assign head = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_item;
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ rtl/core/hld_back.sv @@
// Back end: weight store, table build walk, stream decode.
// Depends on hld_pkg.
module hld_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            avail,
  input  hld_pkg::item_t  head,
  output logic            pop,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_symbol,
  output logic [2:0]      out_status,
  output logic [3:0]      out_tree_depth,
  output logic            out_last
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_SUM = 7'b0000010, S_CHECK = 7'b0000100,
    S_FILL = 7'b0001000, S_LOOK = 7'b0010000, S_DEC = 7'b0100000,
    S_SHORT = 7'b1000000
  } state_t;
  state_t st_r;

  logic [3:0] wmem [hld_pkg::SymbolCount];
  logic [11:0] tmem [hld_pkg::TableSize];
  logic [8:0] wcnt_r, n_r;
  logic [8:0] idx_r;
  logic [3:0] wrd_r, wt_r, maxb_r;
  // weight total can reach 255 * 2^14, so the lowest set bit goes up to bit 21
  logic [4:0] lw_r;
  logic [22:0] sum_r;
  logic [11:0] code_r;
  logic [11:0] rep_r;
  logic [31:0] buf_r;
  logic [5:0] held_r;
  logic [17:0] left_r;
  logic pend_r, ready_r, fin_r, rd_ok_r;
  logic [11:0] ent_r;

  // build walk and decode helpers
  logic [3:0] wsel;
  logic [10:0] tidx;
  logic [3:0] elen;
  logic [7:0] fb;
  logic [2:0] top;
  logic [22:0] total;

  function automatic logic [3:0] elen_w(input logic [3:0] mb, input logic [3:0] w);
    elen_w = mb + 4'd1 - w;
  endfunction

  assign wsel = (idx_r == n_r) ? lw_r[3:0] : ((idx_r < n_r) ? wrd_r : 4'd0);

  always_comb begin
    if (held_r >= 6'd11) tidx = 11'(buf_r >> (held_r - 6'd11));
    else tidx = 11'(buf_r << (6'd11 - held_r));
  end
  assign elen = ent_r[11:8];
  assign fb = head.value;
  always_comb begin
    top = 3'd0;
    for (int i = 1; i < 8; i++) if (fb[i]) top = 3'(i);
  end
  assign total = sum_r + (23'd1 << (lw_r - 5'd1));

  always_ff @(posedge clk) begin
    wrd_r <= wmem[idx_r[7:0]];
    ent_r <= tmem[tidx];
    if (st_r == S_IDLE && avail && !pop && head.cmd == hld_pkg::CMD_WEIGHT &&
        wcnt_r < 9'd255)
      wmem[wcnt_r[7:0]] <= head.value[3:0];
    if (st_r == S_FILL && rd_ok_r && wsel == wt_r && wt_r != 4'd0)
      tmem[code_r[10:0]] <= {elen_w(maxb_r, wt_r), idx_r[7:0]};
  end

  logic [11:0] cnt_fill;
  assign cnt_fill = 12'd1 << (4'd11 - elen_w(maxb_r, wt_r));

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    out_symbol <= 8'd0;
    out_status <= hld_pkg::ST_OK;
    out_tree_depth <= 4'd0;
    out_last <= 1'b0;
    out_kind <= hld_pkg::KIND_LIT;
    pop <= 1'b0;
    if (!rst_n) begin
      st_r <= S_IDLE;
      wcnt_r <= '0;
      buf_r <= '0;
      held_r <= '0;
      left_r <= '0;
      pend_r <= 1'b0;
      ready_r <= 1'b0;
      rd_ok_r <= 1'b0;
      idx_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: if (avail && !pop) begin
          pop <= 1'b1;
          fin_r <= head.fin;
          case (head.cmd)
            hld_pkg::CMD_WEIGHT:
              if (wcnt_r < 9'd256) wcnt_r <= wcnt_r + 9'd1;
            hld_pkg::CMD_BUILD: begin
              n_r <= wcnt_r;
              wcnt_r <= '0;
              left_r <= '0;
              pend_r <= 1'b0;
              ready_r <= 1'b0;
              if (wcnt_r == 9'd256) begin
                out_valid <= 1'b1;
                out_kind <= hld_pkg::KIND_BUILD;
                out_status <= hld_pkg::ST_MANY;
              end else begin
                sum_r <= '0;
                idx_r <= '0;
                rd_ok_r <= 1'b0;
                st_r <= S_SUM;
              end
            end
            hld_pkg::CMD_START: begin
              buf_r <= '0;
              held_r <= '0;
              pend_r <= 1'b0;
              left_r <= '0;
              if (!ready_r) begin
                out_valid <= 1'b1;
                out_kind <= hld_pkg::KIND_ERR;
                out_status <= hld_pkg::ST_NOSYM;
              end else begin
                left_r <= head.count;
                pend_r <= head.count != 18'd0;
              end
            end
            default: if (left_r != 18'd0) begin
              if (pend_r) begin
                pend_r <= 1'b0;
                if (fb == 8'd0) begin
                  left_r <= '0;
                  out_valid <= 1'b1;
                  out_kind <= hld_pkg::KIND_ERR;
                  out_status <= hld_pkg::ST_ZERO;
                end else begin
                  held_r <= 6'(top);
                  buf_r <= 32'(fb & ((8'd1 << top) - 8'd1));
                  st_r <= S_LOOK;
                end
              end else begin
                buf_r <= {buf_r[23:0], fb};
                held_r <= held_r + 6'd8;
                st_r <= S_LOOK;
              end
            end
          endcase
        end
        S_SUM: begin
          // address cycle, then data cycle for each weight
          rd_ok_r <= ~rd_ok_r;
          if (rd_ok_r) begin
            if (idx_r < n_r && wrd_r != 4'd0)
              sum_r <= sum_r + (23'd1 << (wrd_r - 4'd1));
            if (idx_r == n_r) begin
              st_r <= S_CHECK;
              lw_r <= 5'd1;
            end else begin
              idx_r <= idx_r + 9'd1;
            end
          end
        end
        S_CHECK: begin
          if (sum_r == 23'd0) begin
            out_valid <= 1'b1;
            out_kind <= hld_pkg::KIND_BUILD;
            out_status <= hld_pkg::ST_NOSYM;
            st_r <= S_IDLE;
          end else if (sum_r[lw_r - 5'd1] == 1'b0) begin
            lw_r <= lw_r + 5'd1;
          end else if ((total & (total - 23'd1)) != 23'd0) begin
            out_valid <= 1'b1;
            out_kind <= hld_pkg::KIND_BUILD;
            out_status <= hld_pkg::ST_INCOMPLETE;
            st_r <= S_IDLE;
          end else if (total > 23'd2048) begin
            out_valid <= 1'b1;
            out_kind <= hld_pkg::KIND_BUILD;
            out_status <= hld_pkg::ST_DEEP;
            st_r <= S_IDLE;
          end else begin
            maxb_r <= '0;
            for (int b = 1; b <= 11; b++) if (total[b]) maxb_r <= 4'(b);
            wt_r <= 4'd1;
            idx_r <= '0;
            code_r <= '0;
            rep_r <= '0;
            rd_ok_r <= 1'b0;
            st_r <= S_FILL;
          end
        end
        S_FILL: begin
          // per weight, scan symbols; each match writes its entries one a cycle
          if (!rd_ok_r) rd_ok_r <= 1'b1;
          else if (wsel == wt_r && rep_r + 12'd1 < cnt_fill) begin
            rep_r <= rep_r + 12'd1;
            code_r <= code_r + 12'd1;
          end else begin
            if (wsel == wt_r) code_r <= code_r + 12'd1;
            rep_r <= '0;
            rd_ok_r <= 1'b0;
            if (idx_r == n_r) begin
              idx_r <= '0;
              if (wt_r == maxb_r) begin
                ready_r <= 1'b1;
                out_valid <= 1'b1;
                out_kind <= hld_pkg::KIND_BUILD;
                out_tree_depth <= maxb_r;
                st_r <= S_IDLE;
              end else wt_r <= wt_r + 4'd1;
            end else idx_r <= idx_r + 9'd1;
          end
        end
        S_LOOK: st_r <= S_DEC;
        S_DEC: begin
          if (left_r == 18'd0) st_r <= S_IDLE;
          else if (elen == 4'd0 || 6'(elen) > held_r) st_r <= fin_r ? S_SHORT : S_IDLE;
          else begin
            held_r <= held_r - 6'(elen);
            buf_r <= buf_r & ((32'd1 << (held_r - 6'(elen))) - 32'd1);
            left_r <= left_r - 18'd1;
            out_valid <= 1'b1;
            out_kind <= hld_pkg::KIND_LIT;
            out_symbol <= ent_r[7:0];
            out_last <= left_r == 18'd1;
            st_r <= S_LOOK;
          end
        end
        S_SHORT: begin
          left_r <= '0;
          out_valid <= 1'b1;
          out_kind <= hld_pkg::KIND_ERR;
          out_status <= hld_pkg::ST_SHORT;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/huffman_literal_decoder.sv @@
// Huffman literal decoder top level: front queue feeding the back end.
// The back end takes one transaction at a time. A weight is stored; a build sums
// the weights, checks the total, then fills the table; a stream byte decodes its
// literals, with a short-data error on a final byte that runs out. A 2-entry queue
// sets busy when full. Sync active-low reset clears control; tables undefined.
module huffman_literal_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_value,
  input  logic [17:0] in_literal_count,
  input  logic        in_final_byte,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_symbol,
  output logic [2:0]  out_status,
  output logic [3:0]  out_tree_depth,
  output logic        out_last
);
  hld_pkg::item_t in_item, head;
  logic avail, pop;
  assign in_item = '{cmd: in_command, value: in_value, count: in_literal_count,
                     fin: in_final_byte};

  hld_front u_front (.clk, .rst_n, .push(start && !busy), .push_item(in_item),
    .full(busy), .pop, .avail, .head);

  hld_back u_back (.clk, .rst_n, .avail, .head, .pop, .out_valid, .out_kind,
    .out_symbol, .out_status, .out_tree_depth, .out_last);
endmodule
